>>> rtl/linear_probe_hash_map_macros.svh
// Assertion macros for the linear probing hash map
`ifndef LINEAR_PROBE_HASH_MAP_MACROS_SVH
`define LINEAR_PROBE_HASH_MAP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LPH_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("lph assertion failed");

`define LPH_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lph assertion failed");

`define LPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lph assertion failed");

`else

`define LPH_ASSERT_ALWAYS(label, clk, rst, expr)
`define LPH_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define LPH_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/lph_pkg.sv
// Package: shared types and constants of the linear probing hash map
`timescale 1ns / 1ps

package lph_pkg;

   localparam int CAPACITY_DEFAULT   = 128;
   localparam int KEY_BITS_DEFAULT   = 64;
   localparam int VALUE_BITS_DEFAULT = 64;

   localparam int HASH_W  = 32;
   localparam int FIELD_W = 64;
   localparam int CFG_W   = 7;

   localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 7'd96;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_SET = 1'b1;

   typedef enum logic [2:0] {
      ST_GET_HIT      = 3'd0,
      ST_GET_MISS     = 3'd1,
      ST_SET_INSERTED = 3'd2,
      ST_SET_UPDATED  = 3'd3,
      ST_SET_FULL     = 3'd4
   } status_type;

   typedef struct packed {
      logic               func;
      logic [HASH_W-1:0]  key_hash;
      logic [FIELD_W-1:0] key_word;
      logic [FIELD_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [FIELD_W-1:0] value_out;
   } rsp_type;

endpackage

>>> rtl/linear_probe_hash_map.sv
// Top level: linear probing hash map with get and set items
//
// Items enter on req_valid / req_stall and leave on rsp_valid / rsp_stall; one
// result leaves for every item. csr_wr_en with csr_wr_data sets the load limit
// (reset value 96); write it only while the block is idle.
// After reset the block clears the used flags of the slot memory, one slot a
// cycle, through all CAPACITY slots (128 by default) with req_stall held high.
// An item's result is loaded into the output register once its probe ends and
// the register is free, P being the number of slots probed (1 to CAPACITY): each
// probe is one read of the slot memory, whose read port is registered. When
// CAPACITY is not a power of two, the start slot is first reduced from the hash
// four bits a cycle. The next item can be accepted in the cycle after a result
// is loaded; the block takes no new item while one is still being probed.
// The result register parts the two sides: while the receiver stalls, the held
// result stays and the block takes and probes the next item, then holds that
// item's result until the register frees.
`timescale 1ns / 1ps

`include "linear_probe_hash_map_macros.svh"

module linear_probe_hash_map #(
   parameter int CAPACITY   = lph_pkg::CAPACITY_DEFAULT,
   parameter int KEY_BITS   = lph_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = lph_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  lph_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output lph_pkg::rsp_type           rsp_data,
   input  logic                       csr_wr_en,
   input  logic [lph_pkg::CFG_W-1:0]  csr_wr_data
);

   import lph_pkg::*;

   localparam int  IDX_W     = $clog2(CAPACITY);
   localparam int  IDXP_W    = IDX_W + 1;
   localparam int  CNT_W     = $clog2(CAPACITY + 1);
   localparam int  CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int  DATA_W    = 1 + HASH_W + KEY_BITS + VALUE_BITS;
   localparam int  MOD_BITS  = 4;
   localparam int  MOD_STEPS = HASH_W / MOD_BITS;
   localparam int  STEP_W    = $clog2(MOD_STEPS);
   localparam bit  POW2      = (CAPACITY & (CAPACITY - 1)) == 0;

   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CAPACITY - 1);
   localparam logic [IDX_W:0]    REM_CAP   = IDXP_W'(CAPACITY);
   localparam logic [CNT_W-1:0]  CAP_COUNT = CNT_W'(CAPACITY);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MOD_STEPS - 1);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_HASH  = 4'b0100,
      S_CHECK = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      clr_idx_ff, clr_idx_in;
   logic [CNT_W-1:0]      used_count_ff, used_count_in;
   logic [CFG_W-1:0]      max_entries_ff, max_entries_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  func_ff;
   logic [HASH_W-1:0]     hash_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic [IDX_W-1:0]      rem_ff, rem_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [HASH_W-1:0]     hash_sh_ff, hash_sh_in;

   logic                  req_take;
   logic                  rsp_load;
   logic                  rsp_free;
   logic                  ins_fire;
   logic [IDX_W-1:0]      rem_step;
   logic [IDX_W-1:0]      next_idx;

   logic                  mem_wr_en;
   logic [IDX_W-1:0]      mem_wr_addr;
   logic [DATA_W-1:0]     mem_wr_data;
   logic                  mem_rd_en;
   logic [IDX_W-1:0]      mem_rd_addr;
   logic [DATA_W-1:0]     mem_rd_data;

   logic                  rd_used;
   logic [HASH_W-1:0]     rd_hash;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_value;
   logic                  match;
   logic                  found_used;
   logic                  done;
   logic                  no_room;

   lph_slot_mem #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W),
      .DATA_W (DATA_W)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rd_used  = mem_rd_data[DATA_W-1];
   assign rd_hash  = mem_rd_data[DATA_W-2 -: HASH_W];
   assign rd_key   = mem_rd_data[KEY_BITS+VALUE_BITS-1 -: KEY_BITS];
   assign rd_value = mem_rd_data[VALUE_BITS-1:0];

   assign match      = !rd_used || ((rd_hash == hash_ff) && (rd_key == key_ff));
   assign found_used = match && rd_used;
   assign done       = match || (cnt_ff == LAST_IDX);
   assign no_room    = !match
                    || (CMP_W'(used_count_ff) >= CMP_W'(max_entries_ff))
                    || (used_count_ff >= CAP_COUNT);
   assign next_idx   = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      logic [IDX_W-1:0] rem_acc;
      logic [IDX_W:0]   rem_try;
      rem_acc = rem_ff;
      for (int i = 0; i < MOD_BITS; i++) begin
         rem_try = {rem_acc, hash_sh_ff[HASH_W-1-i]};
         if (rem_try >= REM_CAP) begin
            rem_try = rem_try - REM_CAP;
         end
         rem_acc = rem_try[IDX_W-1:0];
      end
      rem_step = rem_acc;
   end

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      used_count_in = used_count_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      hash_sh_in    = hash_sh_ff;
      req_take      = 1'b0;
      rsp_load      = 1'b0;
      ins_fire      = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = idx_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff;
      mem_wr_data   = {1'b1, hash_ff, key_ff, value_ff};
      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_idx_ff;
            mem_wr_data = '0;
            clr_idx_in  = clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_take = 1'b1;
               cnt_in   = '0;
               if (POW2) begin
                  idx_in      = req_data.key_hash[IDX_W-1:0];
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = req_data.key_hash[IDX_W-1:0];
                  state_in    = S_CHECK;
               end else begin
                  rem_in     = '0;
                  step_in    = '0;
                  hash_sh_in = req_data.key_hash;
                  state_in   = S_HASH;
               end
            end
         end
         S_HASH: begin
            hash_sh_in = hash_sh_ff << MOD_BITS;
            step_in    = step_ff + 1'b1;
            rem_in     = rem_step;
            if (step_ff == LAST_STEP) begin
               idx_in      = rem_step;
               mem_rd_en   = 1'b1;
               mem_rd_addr = rem_step;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!done) begin
               idx_in      = next_idx;
               cnt_in      = cnt_ff + 1'b1;
               mem_rd_en   = 1'b1;
               mem_rd_addr = next_idx;
            end else if (rsp_free) begin
               rsp_load              = 1'b1;
               state_in              = S_IDLE;
               rsp_data_in.value_out = '0;
               if (func_ff == FUNC_GET) begin
                  if (found_used) begin
                     rsp_data_in.status    = ST_GET_HIT;
                     rsp_data_in.value_out = FIELD_W'(rd_value);
                  end else begin
                     rsp_data_in.status = ST_GET_MISS;
                  end
               end else if (found_used) begin
                  rsp_data_in.status = ST_SET_UPDATED;
                  mem_wr_en          = 1'b1;
               end else if (no_room) begin
                  rsp_data_in.status = ST_SET_FULL;
               end else begin
                  rsp_data_in.status = ST_SET_INSERTED;
                  mem_wr_en          = 1'b1;
                  ins_fire           = 1'b1;
                  used_count_in      = used_count_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign max_entries_in = csr_wr_en ? csr_wr_data : max_entries_ff;
   assign rsp_valid_in   = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_idx_ff     <= '0;
         used_count_ff  <= '0;
         max_entries_ff <= MAX_ENTRIES_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_idx_ff     <= clr_idx_in;
         used_count_ff  <= used_count_in;
         max_entries_ff <= max_entries_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff  <= req_data.func;
         hash_ff  <= req_data.key_hash;
         key_ff   <= req_data.key_word[KEY_BITS-1:0];
         value_ff <= req_data.value_in[VALUE_BITS-1:0];
      end
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      hash_sh_ff  <= hash_sh_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `LPH_ASSERT_ALWAYS(a_count_cap, clock, reset, used_count_ff <= CAP_COUNT)
   `LPH_ASSERT_IMPLIES(a_insert_limit, clock, reset, ins_fire, CMP_W'(used_count_ff) < CMP_W'(max_entries_ff))
   `LPH_ASSERT_NEXT(a_insert_count, clock, reset, ins_fire, used_count_ff == $past(used_count_ff) + 1'b1)
   `LPH_ASSERT_IMPLIES(a_value_zero, clock, reset, rsp_valid_ff && (rsp_data_ff.status != ST_GET_HIT), rsp_data_ff.value_out == '0)

endmodule

>>> rtl/lph_slot_mem.sv
// Slot memory: one write port, one registered read port
`timescale 1ns / 1ps

module lph_slot_mem #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7,
   parameter int DATA_W = 161
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the linear probing hash map
`timescale 1ns / 1ps

module testbench;
   import lph_pkg::*;

   localparam int SLOTS = CAPACITY_DEFAULT;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 2 * SLOTS + 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   // shadow of the slot table
   bit map_used[SLOTS];
   logic [HASH_W-1:0] map_hash[SLOTS];
   logic [FIELD_W-1:0] map_key[SLOTS];
   logic [FIELD_W-1:0] map_value[SLOTS];
   int unsigned map_count = 0;
   int unsigned load_limit = MAX_ENTRIES_RESET;

   req_type queued_requests[$];
   rsp_type awaited_results[$];
   logic [HASH_W-1:0] known_hashes[$];
   logic [FIELD_W-1:0] known_keys[$];

   int send_idle_pct = 36;
   int recv_idle_pct = 36;
   int hold_requests = 0;
   int holds_granted = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int mismatches = 0;
   int hot_base = 120;
   rsp_type want;

   linear_probe_hash_map i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   function automatic rsp_type apply_request(req_type r);
      int unsigned idx;
      int unsigned pos;
      bit found;
      rsp_type res;
      idx = r.key_hash % SLOTS;
      pos = 0;
      found = 1'b0;
      res.status = ST_GET_MISS;
      res.value_out = '0;
      for (int n = 0; n < SLOTS && !found; n++) begin
         if (!map_used[idx] || (map_hash[idx] == r.key_hash && map_key[idx] == r.key_word)) begin
            found = 1'b1;
            pos = idx;
         end else begin
            idx = (idx + 1) % SLOTS;
         end
      end
      if (r.func == FUNC_GET) begin
         if (found && map_used[pos]) begin
            res.status = ST_GET_HIT;
            res.value_out = map_value[pos];
         end
      end else if (found && map_used[pos]) begin
         map_value[pos] = r.value_in;
         res.status = ST_SET_UPDATED;
      end else if (!found || map_count + 1 > load_limit || map_count >= SLOTS) begin
         res.status = ST_SET_FULL;
      end else begin
         map_used[pos] = 1'b1;
         map_hash[pos] = r.key_hash;
         map_key[pos] = r.key_word;
         map_value[pos] = r.value_in;
         map_count++;
         res.status = ST_SET_INSERTED;
      end
      return res;
   endfunction

   // driver: offer queued items, predict each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_results.push_back(apply_request(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (queued_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= queued_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check results in order, drive stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result: status %0d value %h",
                           rsp_data.status, rsp_data.value_out);
               end
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.status !== want.status || rsp_data.value_out !== want.value_out) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected status %0d value %h, got status %0d value %h",
                              want.status, want.value_out, rsp_data.status, rsp_data.value_out);
                  end
               end
            end
         end
         if (holds_granted != hold_requests) begin
            holds_granted <= holds_granted + 1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("linear_probe_hash_map regression: fail");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic drain();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_valid || awaited_results.size() != 0);
   endtask

   task automatic write_limit(logic [CFG_W-1:0] limit);
      drain();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= limit;
      load_limit = limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic queue_item(logic func, logic [HASH_W-1:0] hash, logic [FIELD_W-1:0] key,
                             logic [FIELD_W-1:0] value);
      req_type r;
      r.func = func;
      r.key_hash = hash;
      r.key_word = key;
      r.value_in = value;
      queued_requests.push_back(r);
      if (func == FUNC_SET) begin
         known_hashes.push_back(hash);
         known_keys.push_back(key);
      end
   endtask

   task automatic queue_random(int count);
      logic [HASH_W-1:0] h;
      logic [FIELD_W-1:0] k;
      int pick;
      int choice;
      repeat (count) begin
         choice = $urandom_range(0, 99);
         pick = $urandom_range(0, known_keys.size() - 1);
         h = $urandom;
         k = {$urandom, $urandom};
         if (choice < 40) begin
            case ($urandom_range(0, 4))
               0: ;
               1, 2: h[SLOT_BITS-1:0] = SLOT_BITS'(hot_base + $urandom_range(0, 15));
               3: h = known_hashes[pick];
               default: k = known_keys[pick];
            endcase
            queue_item(FUNC_SET, h, k, {$urandom, $urandom});
         end else if (choice < 65) begin
            queue_item(FUNC_SET, known_hashes[pick], known_keys[pick], {$urandom, $urandom});
         end else if (choice < 90) begin
            queue_item(FUNC_GET, known_hashes[pick], known_keys[pick], {$urandom, $urandom});
         end else begin
            h[SLOT_BITS-1:0] = SLOT_BITS'(hot_base + $urandom_range(0, 15));
            queue_item(FUNC_GET, h, k, {$urandom, $urandom});
         end
      end
   endtask

   initial begin
      foreach (map_used[i]) map_used[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero limit: refuse every new key
      write_limit(7'd0);
      queue_item(FUNC_GET, 32'h0, 64'h0, 64'h0);
      queue_item(FUNC_SET, '1, '1, '1);
      queue_item(FUNC_GET, '1, '1, 64'h0);
      queue_item(FUNC_SET, 32'h80, 64'h0, 64'h0);

      // limit one: insert, hit, update, refuse on wrap
      write_limit(7'd1);
      queue_item(FUNC_SET, '1, '1, '1);
      queue_item(FUNC_GET, '1, '1, 64'h0);
      queue_item(FUNC_SET, '1, '1, 64'h0);
      queue_item(FUNC_GET, '1, '1, '1);
      queue_item(FUNC_SET, 32'h7F, 64'h1, 64'h1);
      queue_item(FUNC_GET, 32'h7F, 64'h1, 64'h0);

      // small limit: collisions, wrap, partial matches
      write_limit(7'd6);
      queue_item(FUNC_SET, '1, 64'h0, {32{2'b10}});
      queue_item(FUNC_SET, 32'h7F, '1, {32{2'b01}});
      queue_item(FUNC_SET, 32'h0, 64'h0, 64'h0123_4567_89AB_CDEF);
      queue_item(FUNC_GET, 32'h0, 64'h0, 64'h0);
      queue_item(FUNC_GET, '1, 64'h0, 64'h0);
      queue_item(FUNC_GET, 32'h7F, '1, 64'h0);
      queue_item(FUNC_GET, 32'h80, 64'h0, 64'h0);
      queue_item(FUNC_SET, 32'h1234_5678, 64'hDEAD_BEEF_0BAD_F00D, 64'hFEDC_BA98_7654_3210);
      queue_item(FUNC_SET, 32'h8765_4321, 64'h5A5A_5A5A_A5A5_A5A5, 64'h1);
      queue_item(FUNC_SET, 32'h0000_0003, 64'h3, 64'h3);
      queue_item(FUNC_SET, '1, 64'h0, '1);

      write_limit(MAX_ENTRIES_RESET);
      queue_random(220);

      // long stretch with no idling on either side
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(100);

      // hold the receiver off while items keep coming
      drain();
      send_idle_pct = 36;
      recv_idle_pct = 36;
      hold_requests = hold_requests + 1;
      queue_random(60);

      write_limit(7'd0);
      queue_random(60);

      write_limit(7'd127);
      hot_base = 60;
      queue_random(140);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("linear_probe_hash_map regression: pass");
      end else begin
         $display("linear_probe_hash_map regression: fail");
      end
      $finish;
   end

endmodule

>>> linear_probe_hash_map.f
+incdir+rtl
rtl/lph_pkg.sv
rtl/lph_slot_mem.sv
rtl/linear_probe_hash_map.sv
dv/testbench.sv
